[design/dsts_pkg.sv]
// Shared types and constants of the dequantized score top-3 selector.
package dsts_pkg;

  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 32;
  localparam int SCORE_W     = 48;
  localparam int CLASS_W     = 5;
  localparam int NUM_SLOTS   = 3;
  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [1:0] {
    MODE_INT8  = 2'd0,
    MODE_UINT8 = 2'd1,
    MODE_RAW   = 2'd2,
    MODE_ZERO  = 2'd3
  } score_mode_e;

  localparam logic [CFG_IDX_W-1:0] REG_SCORE_MODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ZP_OFFSET  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE      = 2'd2;

  localparam logic [31:0]        SCALE_RESET = 32'd16777216;
  localparam logic [CLASS_W-1:0] CLASS_NONE  = '1;

  typedef struct packed {
    score_mode_e        mode;
    logic signed [8:0]  zp_offset;
    logic [31:0]        scale;
  } cfg_t;

  typedef struct packed {
    logic signed [SCORE_W-1:0] score;
    logic [CLASS_W-1:0]        cls;
    logic                      rank;
    logic                      last;
  } entry_t;

  typedef struct packed {
    logic not_empty;
    logic not_full;
  } queue_stat_t;

endpackage

[design/dsts_if.sv]
// Channel interfaces: score input, top-3 result output and register writes.
interface dsts_in_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [8:0]                    q_value;
  logic signed [dsts_pkg::SCORE_W-1:0]  raw_score;
  logic                                 last_element;

  modport source (output valid, q_value, raw_score, last_element, input ready);
  modport sink   (input valid, q_value, raw_score, last_element, output ready);
endinterface

interface dsts_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [dsts_pkg::CLASS_W-1:0]  first_class;
  logic signed [dsts_pkg::SCORE_W-1:0]  first_score;
  logic signed [dsts_pkg::CLASS_W-1:0]  second_class;
  logic signed [dsts_pkg::SCORE_W-1:0]  second_score;
  logic signed [dsts_pkg::CLASS_W-1:0]  third_class;
  logic signed [dsts_pkg::SCORE_W-1:0]  third_score;

  modport source (output valid, first_class, first_score, second_class, second_score,
                  third_class, third_score, input ready);
  modport sink   (input valid, first_class, first_score, second_class, second_score,
                  third_class, third_score, output ready);
endinterface

interface dsts_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [dsts_pkg::CFG_IDX_W-1:0]     reg_index;
  logic [dsts_pkg::CFG_DATA_W-1:0]    wr_data;

  modport source (output valid, reg_index, wr_data, input ready);
  modport sink   (input valid, reg_index, wr_data, output ready);
endinterface

[design/dsts_queue.sv]
// Short queue of dequantized, classified scores between front and back.
module dsts_queue (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push_i,
  input  dsts_pkg::entry_t       entry_i,
  input  logic                   pop_i,
  output dsts_pkg::entry_t       entry_o,
  output dsts_pkg::queue_stat_t  stat_o
);

  localparam int PtrW = (dsts_pkg::QUEUE_DEPTH > 1) ? $clog2(dsts_pkg::QUEUE_DEPTH) : 1;
  localparam int CntW = $clog2(dsts_pkg::QUEUE_DEPTH + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(dsts_pkg::QUEUE_DEPTH - 1);

  dsts_pkg::entry_t mem_q [dsts_pkg::QUEUE_DEPTH];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

  assign entry_o          = mem_q[rd_ptr_q];
  assign stat_o.not_empty = (cnt_q != '0);
  assign stat_o.not_full  = (cnt_q != CntW'(dsts_pkg::QUEUE_DEPTH));

endmodule

[design/dsts_front.sv]
// Front end: accepts scores, dequantizes them and tags class index and rank.
module dsts_front #(
  parameter int MAX_CLASSES = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  dsts_in_if.sink                in_i,
  input  dsts_pkg::cfg_t         cfg_i,
  input  dsts_pkg::queue_stat_t  stat_i,
  output logic                   push_o,
  output dsts_pkg::entry_t       entry_o
);

  localparam int IdxW = $clog2(MAX_CLASSES + 1);

  logic [IdxW-1:0]                     idx_q, idx_d;
  logic                                rank;
  logic signed [8:0]                   qv;
  logic signed [9:0]                   diff;
  logic signed [42:0]                  prod;
  logic signed [dsts_pkg::SCORE_W-1:0] score;

  assign in_i.ready = stat_i.not_full;
  assign push_o     = in_i.valid && stat_i.not_full;

  // int8 reads the low byte as signed, uint8 as unsigned
  assign qv   = (cfg_i.mode == dsts_pkg::MODE_INT8) ?
                {in_i.q_value[7], in_i.q_value[7:0]} : {1'b0, in_i.q_value[7:0]};
  assign diff = {qv[8], qv} - {cfg_i.zp_offset[8], cfg_i.zp_offset};
  assign prod = diff * $signed({1'b0, cfg_i.scale});

  always_comb begin
    case (cfg_i.mode)
      dsts_pkg::MODE_INT8,
      dsts_pkg::MODE_UINT8: score = {{(dsts_pkg::SCORE_W - 43){prod[42]}}, prod};
      dsts_pkg::MODE_RAW:   score = in_i.raw_score;
      default:              score = '0;
    endcase
  end

  assign rank = (idx_q < IdxW'(MAX_CLASSES));

  always_comb begin
    idx_d = idx_q;
    if (push_o) begin
      if (in_i.last_element) begin
        idx_d = '0;
      end else if (rank) begin
        idx_d = idx_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
    end else begin
      idx_q <= idx_d;
    end
  end

  assign entry_o.score = score;
  assign entry_o.cls   = dsts_pkg::CLASS_W'(idx_q);
  assign entry_o.rank  = rank;
  assign entry_o.last  = in_i.last_element;

endmodule

[design/dsts_back.sv]
// Back end: keeps the sorted best-three list and emits it on the last element.
module dsts_back (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  dsts_pkg::entry_t       entry_i,
  input  dsts_pkg::queue_stat_t  stat_i,
  output logic                   pop_o,
  dsts_out_if.source             res_o
);

  localparam int NS = dsts_pkg::NUM_SLOTS;

  logic signed [dsts_pkg::SCORE_W-1:0] score_q   [NS];
  logic [dsts_pkg::CLASS_W-1:0]        cls_q     [NS];
  logic                                filled_q  [NS];
  logic signed [dsts_pkg::SCORE_W-1:0] prev_score[NS];
  logic [dsts_pkg::CLASS_W-1:0]        prev_cls  [NS];
  logic                                prev_fill [NS];
  logic signed [dsts_pkg::SCORE_W-1:0] score_d   [NS];
  logic [dsts_pkg::CLASS_W-1:0]        cls_d     [NS];
  logic                                filled_d  [NS];
  logic [NS-1:0]                       ins;

  logic signed [dsts_pkg::SCORE_W-1:0] res_score_q[NS];
  logic [dsts_pkg::CLASS_W-1:0]        res_cls_q  [NS];
  logic                                out_valid_q, out_valid_d;

  // Hold a finished result until taken; other elements may still flow
  assign pop_o = stat_i.not_empty && (!entry_i.last || !out_valid_q || res_o.ready);

  always_comb begin
    for (int k = 0; k < NS; k++) begin
      ins[k] = entry_i.rank && (!filled_q[k] || (entry_i.score > score_q[k]));
      if (k == 0) begin
        prev_score[k] = score_q[k];
        prev_cls[k]   = cls_q[k];
        prev_fill[k]  = filled_q[k];
      end else begin
        prev_score[k] = score_q[k-1];
        prev_cls[k]   = cls_q[k-1];
        prev_fill[k]  = filled_q[k-1];
      end
    end
  end

  // Slots beaten by the new score form a suffix: insert at its head, shift the rest down
  always_comb begin
    logic taken;
    taken = 1'b0;
    for (int k = 0; k < NS; k++) begin
      if (ins[k] && !taken) begin
        score_d[k]  = entry_i.score;
        cls_d[k]    = entry_i.cls;
        filled_d[k] = 1'b1;
      end else if (ins[k]) begin
        score_d[k]  = prev_score[k];
        cls_d[k]    = prev_cls[k];
        filled_d[k] = prev_fill[k];
      end else begin
        score_d[k]  = score_q[k];
        cls_d[k]    = cls_q[k];
        filled_d[k] = filled_q[k];
      end
      taken = taken | ins[k];
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (pop_o && entry_i.last) begin
      out_valid_d = 1'b1;
    end else if (res_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      for (int k = 0; k < NS; k++) begin
        score_q[k]  <= '0;
        cls_q[k]    <= dsts_pkg::CLASS_NONE;
        filled_q[k] <= 1'b0;
      end
    end else begin
      out_valid_q <= out_valid_d;
      if (pop_o) begin
        for (int k = 0; k < NS; k++) begin
          if (entry_i.last) begin
            score_q[k]  <= '0;
            cls_q[k]    <= dsts_pkg::CLASS_NONE;
            filled_q[k] <= 1'b0;
          end else begin
            score_q[k]  <= score_d[k];
            cls_q[k]    <= cls_d[k];
            filled_q[k] <= filled_d[k];
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o && entry_i.last) begin
      for (int k = 0; k < NS; k++) begin
        res_score_q[k] <= score_d[k];
        res_cls_q[k]   <= cls_d[k];
      end
    end
  end

  assign res_o.valid        = out_valid_q;
  assign res_o.first_class  = res_cls_q[0];
  assign res_o.first_score  = res_score_q[0];
  assign res_o.second_class = res_cls_q[1];
  assign res_o.second_score = res_score_q[1];
  assign res_o.third_class  = res_cls_q[2];
  assign res_o.third_score  = res_score_q[2];

endmodule

[design/dequantized_score_top3_selector_core.sv]
// Results are registered; one 10x33 multiply in the front, one insert in the back.
// Throughput: 1 element per cycle while the queue has room.
// A pending result stalls only last elements; the 2-entry queue absorbs the rest.
// Reset (async, active low): list empty, element index 0, score_mode int8,
// zero point 0, scale 1.0; no clearing pass.
module dequantized_score_top3_selector_core #(
  parameter int MAX_CLASSES = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  dsts_in_if.sink     in_i,
  dsts_cfg_if.sink    cfg_i,
  dsts_out_if.source  res_o
);

  dsts_pkg::cfg_t        cfg_q;
  dsts_pkg::entry_t      push_entry;
  dsts_pkg::entry_t      head_entry;
  dsts_pkg::queue_stat_t stat;
  logic                  push;
  logic                  pop;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mode      <= dsts_pkg::MODE_INT8;
      cfg_q.zp_offset <= '0;
      cfg_q.scale     <= dsts_pkg::SCALE_RESET;
    end else if (cfg_i.valid) begin
      case (cfg_i.reg_index)
        dsts_pkg::REG_SCORE_MODE: cfg_q.mode <= dsts_pkg::score_mode_e'(cfg_i.wr_data[1:0]);
        dsts_pkg::REG_ZP_OFFSET:  cfg_q.zp_offset <= cfg_i.wr_data[8:0];
        dsts_pkg::REG_SCALE:      cfg_q.scale <= cfg_i.wr_data[31:0];
        default: ;
      endcase
    end
  end

  dsts_front #(
    .MAX_CLASSES(MAX_CLASSES)
  ) u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .cfg_i  (cfg_q),
    .stat_i (stat),
    .push_o (push),
    .entry_o(push_entry)
  );

  dsts_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .entry_i(push_entry),
    .pop_i  (pop),
    .entry_o(head_entry),
    .stat_o (stat)
  );

  dsts_back u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .entry_i(head_entry),
    .stat_i (stat),
    .pop_o  (pop),
    .res_o  (res_o)
  );

  a_push_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> stat.not_empty)
    else $error("accepted element missing from queue");

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> stat.not_empty)
    else $error("pop from empty queue");

  a_result_from_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(res_o.valid) |-> $past(pop && head_entry.last))
    else $error("result raised without a last element");

endmodule

[verif/dequantized_score_top3_selector_core_tb.sv]
// Self-checking testbench of the dequantized score top-3 selector core.
module dequantized_score_top3_selector_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CFG_IDX_W  = dsts_pkg::CFG_IDX_W;
  localparam int CFG_DATA_W = dsts_pkg::CFG_DATA_W;
  localparam int SCORE_W    = dsts_pkg::SCORE_W;
  localparam int CLASS_W    = dsts_pkg::CLASS_W;
  localparam int NUM_SLOTS  = dsts_pkg::NUM_SLOTS;

  localparam int N_CLASSES      = 16;
  localparam int ITEMS_PER_SET  = 134;
  localparam int SETS_PER_MIX   = 3;
  localparam int LONG_HOLD      = 200;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int SETTLE_CYCLES  = 4;

  localparam logic [CFG_IDX_W-1:0]   REG_UNUSED = 2'd3;
  localparam logic signed [SCORE_W-1:0] RAW_MAX = {1'b0, {(SCORE_W-1){1'b1}}};
  localparam logic signed [SCORE_W-1:0] RAW_MIN = {1'b1, {(SCORE_W-1){1'b0}}};

  typedef struct packed {
    logic [NUM_SLOTS-1:0][CLASS_W-1:0] cls;
    logic [NUM_SLOTS-1:0][SCORE_W-1:0] score;
  } top3_t;

  typedef enum logic {ROW_CFG, ROW_SCORE} row_kind_e;

  typedef struct {
    row_kind_e                 kind;
    logic [CFG_IDX_W-1:0]      idx;
    logic [CFG_DATA_W-1:0]     data;
    logic signed [8:0]         q;
    logic signed [SCORE_W-1:0] raw;
    logic                      last;
    bit                        typed;
    top3_t                     want;
  } dir_row_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  dsts_in_if  in_bus ();
  dsts_cfg_if cfg_bus ();
  dsts_out_if res_bus ();

  dequantized_score_top3_selector_core #(
    .MAX_CLASSES(N_CLASSES)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_bus),
    .cfg_i (cfg_bus),
    .res_o (res_bus)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Predictor state: register copies and the running best-three list.
  dsts_pkg::score_mode_e     cur_mode;
  logic signed [8:0]         cur_zp;
  logic [31:0]               cur_scale;
  logic signed [SCORE_W-1:0] slot_score [NUM_SLOTS];
  logic [CLASS_W-1:0]        slot_cls   [NUM_SLOTS];
  bit                        slot_full  [NUM_SLOTS];
  int                        elem_idx;

  top3_t    top3_q [$];
  dir_row_t dir_tab [$];

  int unsigned src_idle_pct = 0;
  int unsigned snk_idle_pct = 0;
  bit          hold_armed   = 1'b0;
  bit          hold_done    = 1'b0;
  int          n_items      = 0;
  int          n_results    = 0;
  int          n_errors     = 0;
  int          idle_cycles  = 0;

  function automatic void clear_slots();
    for (int k = 0; k < NUM_SLOTS; k++) begin
      slot_score[k] = '0;
      slot_cls[k]   = dsts_pkg::CLASS_NONE;
      slot_full[k]  = 1'b0;
    end
    elem_idx = 0;
  endfunction

  function automatic logic signed [SCORE_W-1:0] dequant(input logic signed [8:0] q,
                                                         input logic signed [SCORE_W-1:0] raw);
    longint qv;
    case (cur_mode)
      dsts_pkg::MODE_INT8:  qv = longint'($signed(q[7:0]));
      dsts_pkg::MODE_UINT8: qv = longint'(q[7:0]);
      dsts_pkg::MODE_RAW:   return raw;
      default:              return '0;
    endcase
    return SCORE_W'((qv - longint'(cur_zp)) * longint'(cur_scale));
  endfunction

  // Rank one score; on the last element hand back the list and clear it.
  function automatic bit rank_score(input logic signed [8:0] q,
                                    input logic signed [SCORE_W-1:0] raw,
                                    input logic last, output top3_t res);
    logic signed [SCORE_W-1:0] s;
    bit placed;
    s = dequant(q, raw);
    res = '0;
    if (elem_idx < N_CLASSES) begin
      placed = 1'b0;
      for (int k = 0; k < NUM_SLOTS; k++) begin
        if (!placed && (!slot_full[k] || s > slot_score[k])) begin
          for (int j = NUM_SLOTS - 1; j > k; j--) begin
            slot_score[j] = slot_score[j-1];
            slot_cls[j]   = slot_cls[j-1];
            slot_full[j]  = slot_full[j-1];
          end
          slot_score[k] = s;
          slot_cls[k]   = CLASS_W'(elem_idx);
          slot_full[k]  = 1'b1;
          placed        = 1'b1;
        end
      end
      elem_idx++;
    end
    if (!last) return 1'b0;
    for (int k = 0; k < NUM_SLOTS; k++) begin
      res.cls[k]   = slot_full[k] ? slot_cls[k] : dsts_pkg::CLASS_NONE;
      res.score[k] = slot_full[k] ? slot_score[k] : '0;
    end
    clear_slots();
    return 1'b1;
  endfunction

  function automatic top3_t mk_top3(input logic [CLASS_W-1:0] c0, input logic [SCORE_W-1:0] s0,
                                    input logic [CLASS_W-1:0] c1, input logic [SCORE_W-1:0] s1,
                                    input logic [CLASS_W-1:0] c2, input logic [SCORE_W-1:0] s2);
    top3_t t;
    t.cls[0] = c0;  t.score[0] = s0;
    t.cls[1] = c1;  t.score[1] = s1;
    t.cls[2] = c2;  t.score[2] = s2;
    return t;
  endfunction

  function automatic logic [SCORE_W-1:0] q24(input longint v);
    return SCORE_W'(v <<< 24);
  endfunction

  function automatic void add_cfg(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
    dir_row_t r;
    r = '{kind: ROW_CFG, idx: idx, data: data, q: '0, raw: '0, last: 1'b0,
          typed: 1'b0, want: '0};
    dir_tab.push_back(r);
  endfunction

  function automatic void add_score(input logic signed [8:0] q,
                                    input logic signed [SCORE_W-1:0] raw, input logic last,
                                    input bit typed = 1'b0, input top3_t want = '0);
    dir_row_t r;
    r = '{kind: ROW_SCORE, idx: '0, data: '0, q: q, raw: raw, last: last,
          typed: typed, want: want};
    dir_tab.push_back(r);
  endfunction

  function automatic logic signed [8:0] rand_q();
    case ($urandom_range(0, 7))
      0:       return -9'sd128;
      1:       return 9'sd255;
      default: return 9'(int'($urandom_range(0, 383)) - 128);
    endcase
  endfunction

  function automatic logic signed [SCORE_W-1:0] rand_raw();
    case ($urandom_range(0, 9))
      0:       return RAW_MAX;
      1:       return RAW_MIN;
      2, 3:    return SCORE_W'(int'($urandom_range(0, 2)) - 1);
      default: return SCORE_W'({$urandom(), $urandom()});
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_zp_offset();
    logic signed [8:0] zp;
    case ($urandom_range(0, 3))
      0:       zp = -9'sd128;
      1:       zp = 9'sd255;
      2:       zp = '0;
      default: zp = 9'(int'($urandom_range(0, 383)) - 128);
    endcase
    return CFG_DATA_W'(zp);
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_scale();
    case ($urandom_range(0, 3))
      0:       return '0;
      1:       return '1;
      2:       return dsts_pkg::SCALE_RESET;
      default: return $urandom();
    endcase
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_bus.valid     <= 1'b1;
    cfg_bus.reg_index <= idx;
    cfg_bus.wr_data   <= data;
    do @(posedge clk_i); while (!cfg_bus.ready);
    case (idx)
      dsts_pkg::REG_SCORE_MODE: cur_mode  = dsts_pkg::score_mode_e'(data[1:0]);
      dsts_pkg::REG_ZP_OFFSET:  cur_zp    = data[8:0];
      dsts_pkg::REG_SCALE:      cur_scale = data;
      default: ;
    endcase
  endtask

  task automatic offer_score(input logic signed [8:0] q, input logic signed [SCORE_W-1:0] raw,
                             input logic last, input bit typed, input top3_t want);
    top3_t pred;
    while ($urandom_range(0, 99) < src_idle_pct) begin
      in_bus.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_bus.valid        <= 1'b1;
    in_bus.q_value      <= q;
    in_bus.raw_score    <= raw;
    in_bus.last_element <= last;
    do @(posedge clk_i); while (!in_bus.ready);
    n_items++;
    if (rank_score(q, raw, last, pred)) top3_q.push_back(typed ? want : pred);
  endtask

  // Hold the input until every pending result is out, then let the pipe settle.
  task automatic drain_results();
    in_bus.valid <= 1'b0;
    while (top3_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  initial begin : result_sink
    top3_t got;
    top3_t want;
    int    held;
    res_bus.ready = 1'b0;
    held = 0;
    forever begin
      @(posedge clk_i);
      if (res_bus.valid && res_bus.ready) begin
        got = mk_top3(res_bus.first_class, res_bus.first_score,
                      res_bus.second_class, res_bus.second_score,
                      res_bus.third_class, res_bus.third_score);
        n_results++;
        if (top3_q.size() == 0) begin
          $display("%0t ns: result with nothing expected: class %0d score %0d",
                   $time, $signed(got.cls[0]), $signed(got.score[0]));
          n_errors++;
        end else begin
          want = top3_q.pop_front();
          for (int k = 0; k < NUM_SLOTS; k++) begin
            if (got.cls[k] !== want.cls[k]) begin
              $display("%0t ns: rank %0d class expected %0d actual %0d", $time, k + 1,
                       $signed(want.cls[k]), $signed(got.cls[k]));
              n_errors++;
            end
            if (got.score[k] !== want.score[k]) begin
              $display("%0t ns: rank %0d score expected %0d actual %0d", $time, k + 1,
                       $signed(want.score[k]), $signed(got.score[k]));
              n_errors++;
            end
          end
        end
      end
      if (hold_armed && !hold_done) begin
        hold_done = 1'b1;
        held      = LONG_HOLD;
      end
      if (held != 0) begin
        held--;
        res_bus.ready <= 1'b0;
      end else begin
        res_bus.ready <= ($urandom_range(0, 99) >= snk_idle_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_bus.valid && in_bus.ready) || (cfg_bus.valid && cfg_bus.ready) ||
        (res_bus.valid && res_bus.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t ns: no transaction for %0d cycles, %0d results pending",
               $time, idle_cycles, top3_q.size());
      $display("status: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stimulus
    int n_in_set;
    int vlen;
    int set_no;
    rst_ni               = 1'b0;
    in_bus.valid         = 1'b0;
    in_bus.q_value       = '0;
    in_bus.raw_score     = '0;
    in_bus.last_element  = 1'b0;
    cfg_bus.valid        = 1'b0;
    cfg_bus.reg_index    = '0;
    cfg_bus.wr_data      = '0;
    cur_mode  = dsts_pkg::MODE_INT8;
    cur_zp    = '0;
    cur_scale = dsts_pkg::SCALE_RESET;
    clear_slots();

    // Reset defaults: int8, zero point 0, scale 1.0.
    add_score(9'sd5, '0, 1'b1, 1'b1,
              mk_top3(5'd0, q24(5), dsts_pkg::CLASS_NONE, '0, dsts_pkg::CLASS_NONE, '0));
    // Ties keep the earlier class; the fourth equal score is dropped.
    add_score(9'sd3, '0, 1'b0);
    add_score(9'sd3, '0, 1'b0);
    add_score(9'sd3, '0, 1'b0);
    add_score(9'sd3, '0, 1'b1, 1'b1,
              mk_top3(5'd0, q24(3), 5'd1, q24(3), 5'd2, q24(3)));
    add_score(-9'sd128, '0, 1'b0);
    add_score(9'sd127, '0, 1'b1, 1'b1,
              mk_top3(5'd1, q24(127), 5'd0, q24(-128), dsts_pkg::CLASS_NONE, '0));
    add_score(9'sd255, '0, 1'b0);
    add_score(-9'sd2, '0, 1'b1);
    add_cfg(dsts_pkg::REG_SCORE_MODE, CFG_DATA_W'(dsts_pkg::MODE_UINT8));
    add_score(9'sd255, '0, 1'b0);
    add_score(9'sd0, '0, 1'b1, 1'b1,
              mk_top3(5'd0, q24(255), 5'd1, '0, dsts_pkg::CLASS_NONE, '0));
    add_score(-9'sd128, '0, 1'b0);
    add_score(9'sd200, '0, 1'b1);
    add_cfg(dsts_pkg::REG_ZP_OFFSET, CFG_DATA_W'(9'sd255));
    add_cfg(dsts_pkg::REG_SCALE, '1);
    add_score(9'sd0, '0, 1'b0);
    add_score(9'sd255, '0, 1'b1);
    add_cfg(dsts_pkg::REG_SCORE_MODE, CFG_DATA_W'(dsts_pkg::MODE_INT8));
    add_cfg(dsts_pkg::REG_ZP_OFFSET, CFG_DATA_W'(-9'sd128));
    add_score(9'sd127, '0, 1'b0);
    add_score(-9'sd128, '0, 1'b1);
    // Writes to an index past the register list change nothing.
    add_cfg(REG_UNUSED, '1);
    add_cfg(dsts_pkg::REG_SCORE_MODE, CFG_DATA_W'(dsts_pkg::MODE_RAW));
    add_score(9'sd0, RAW_MAX, 1'b0);
    add_score(9'sd0, RAW_MIN, 1'b1, 1'b1,
              mk_top3(5'd0, RAW_MAX, 5'd1, RAW_MIN, dsts_pkg::CLASS_NONE, '0));
    add_cfg(dsts_pkg::REG_SCORE_MODE, CFG_DATA_W'(dsts_pkg::MODE_ZERO));
    add_score(9'sd255, RAW_MAX, 1'b0);
    add_score(-9'sd128, RAW_MIN, 1'b1, 1'b1,
              mk_top3(5'd0, '0, 5'd1, '0, dsts_pkg::CLASS_NONE, '0));
    add_cfg(dsts_pkg::REG_SCALE, '0);
    add_cfg(dsts_pkg::REG_SCORE_MODE, CFG_DATA_W'(dsts_pkg::MODE_UINT8));
    add_score(9'sd9, '0, 1'b0);
    add_score(9'sd3, '0, 1'b1, 1'b1,
              mk_top3(5'd0, '0, 5'd1, '0, dsts_pkg::CLASS_NONE, '0));

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_tab[i]) begin
      if (dir_tab[i].kind == ROW_CFG) begin
        drain_results();
        write_reg(dir_tab[i].idx, dir_tab[i].data);
        cfg_bus.valid <= 1'b0;
      end else begin
        offer_score(dir_tab[i].q, dir_tab[i].raw, dir_tab[i].last,
                    dir_tab[i].typed, dir_tab[i].want);
      end
    end

    // Three idle mixes, each with several register settings; vectors always close.
    for (int mix = 0; mix < 3; mix++) begin
      for (int sub = 0; sub < SETS_PER_MIX; sub++) begin
        drain_results();
        src_idle_pct = (mix == 0) ? 14 : (mix == 1) ? 86 : 0;
        snk_idle_pct = (mix == 0) ? 86 : (mix == 1) ? 14 : 0;
        set_no = mix * SETS_PER_MIX + sub;
        write_reg(dsts_pkg::REG_SCORE_MODE,
                  CFG_DATA_W'(dsts_pkg::score_mode_e'(set_no % 4)));
        write_reg(dsts_pkg::REG_ZP_OFFSET, pick_zp_offset());
        write_reg(dsts_pkg::REG_SCALE, pick_scale());
        cfg_bus.valid <= 1'b0;
        if (mix == 2 && sub == 1) hold_armed = 1'b1;
        n_in_set = 0;
        while (n_in_set < ITEMS_PER_SET) begin
          // Mostly normal vectors, some that overrun the class count.
          vlen = ($urandom_range(0, 9) == 0) ? $urandom_range(N_CLASSES + 1, N_CLASSES + 8)
                                             : $urandom_range(1, N_CLASSES);
          for (int e = 0; e < vlen; e++) begin
            offer_score(rand_q(), rand_raw(), e == vlen - 1, 1'b0, '0);
          end
          n_in_set += vlen;
        end
      end
    end

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    $display("summary: %0d scores in, %0d top-3 results checked, %0d mismatches",
             n_items, n_results, n_errors);
    $display("summary: all four score modes, register extremes, ties, overlong vectors");
    if (n_errors == 0 && top3_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
